// ===== design/scwh_pkg.sv =====
// Shared types, codes and constants for the sparse column weight histogram.
package scwh_pkg;

    // Default sizes of the weight store.
    localparam int MAX_COLS_DEF    = 65536;
    localparam int WEIGHT_BITS_DEF = 8;

    // Fixed field widths of the transaction payloads.
    localparam int FUNC_W     = 2;
    localparam int COLUMN_W   = 16;
    localparam int CFG_W      = 17;
    localparam int WEIGHT_W   = 8;
    localparam int NONEMPTY_W = 17;
    localparam int TOTAL_W    = 40;

    // Reset value of the column count register and the hard column limit.
    localparam logic [CFG_W-1:0] COLUMN_COUNT_RESET = 17'd65536;
    localparam logic [CFG_W-1:0] COLUMN_LIMIT       = 17'd65536;

    // Command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Operation codes carried in the func field.
    typedef enum logic [FUNC_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_ADD    = 2'd1,
        OP_READ   = 2'd2,
        OP_REPORT = 2'd3
    } op_t;

    // Input transaction payload.
    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [COLUMN_W-1:0] column;
    } in_item_t;

    // Result transaction payload.
    typedef struct packed {
        logic [WEIGHT_W-1:0]   weight;
        logic [NONEMPTY_W-1:0] nonempty_columns;
        logic [TOTAL_W-1:0]    total_weight;
    } out_item_t;

    // Classified command handed from the front to the back.
    typedef struct packed {
        op_t                 op;
        logic                in_range;
        logic [COLUMN_W-1:0] column;
    } cmd_t;

endpackage

// ===== design/scwh_front.sv =====
// Front end: holds the column count register and classifies incoming transactions.
module scwh_front
    import scwh_pkg::*;
#(
    parameter int MAX_COLS = MAX_COLS_DEF,
    localparam int CNT_W = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    input  logic             back_busy,
    input  logic             q_full,
    output logic             q_push,
    output cmd_t             q_cmd,
    output logic [CNT_W-1:0] cols_eff
);

    logic [CFG_W-1:0] column_count_reg;
    logic [CFG_W-1:0] column_count_next;
    logic [CNT_W-1:0] cc_wide;
    logic [CNT_W-1:0] limited;
    logic [CNT_W-1:0] col_wide;

    // Configuration register write.
    always_comb
    begin
        column_count_next = column_count_reg;
        if (cfg_we)
        begin
            column_count_next = cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_count_reg <= COLUMN_COUNT_RESET;
        end
        else
        begin
            column_count_reg <= column_count_next;
        end
    end

    // Columns in effect: the count limited by the index range and the store size.
    always_comb
    begin
        cc_wide = CNT_W'(column_count_reg);
        limited = (cc_wide > CNT_W'(COLUMN_LIMIT)) ? CNT_W'(COLUMN_LIMIT) : cc_wide;
        cols_eff = (limited > CNT_W'(MAX_COLS)) ? CNT_W'(MAX_COLS) : limited;
    end

    // Classify the transaction and push it into the queue.
    always_comb
    begin
        col_wide        = CNT_W'(in_data.column);
        q_cmd.op        = op_t'(in_data.func);
        q_cmd.in_range  = (col_wide < cols_eff);
        q_cmd.column    = in_data.column;
        in_ready        = !q_full && !back_busy;
        q_push          = in_valid && in_ready;
    end

endmodule

// ===== design/scwh_queue.sv =====
// Short command queue that decouples the front end from the back end.
module scwh_queue
    import scwh_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = slot_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ===== design/scwh_back.sv =====
// Back end: weight store, clearing sweeps, read-modify-write and result register.
module scwh_back
    import scwh_pkg::*;
#(
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF,
    localparam int CNT_W = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [CNT_W-1:0] cols_eff,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             q_pop,
    output logic             busy,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data
);

    localparam int ADDR_W = $clog2(MAX_COLS);
    localparam int WIDE_W = (WEIGHT_BITS > WEIGHT_W) ? WEIGHT_BITS : WEIGHT_W;
    localparam logic [WEIGHT_BITS-1:0] W_MAX = {WEIGHT_BITS{1'b1}};

    typedef enum logic [3:0] {
        ST_INIT  = 4'b0001,
        ST_IDLE  = 4'b0010,
        ST_ACT   = 4'b0100,
        ST_CLEAR = 4'b1000
    } state_t;

    state_t                 state_reg;
    state_t                 state_next;
    logic [CNT_W-1:0]       sweep_reg;
    logic [CNT_W-1:0]       sweep_next;
    logic [ADDR_W-1:0]      cur_addr_reg;
    logic [ADDR_W-1:0]      cur_addr_next;
    logic                   cur_range_reg;
    logic                   cur_range_next;
    logic                   cur_add_reg;
    logic                   cur_add_next;
    logic [NONEMPTY_W-1:0]  nonempty_reg;
    logic [NONEMPTY_W-1:0]  nonempty_next;
    logic [TOTAL_W-1:0]     total_reg;
    logic [TOTAL_W-1:0]     total_next;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    out_item_t              out_data_reg;
    out_item_t              out_data_next;

    logic [WEIGHT_BITS-1:0] mem [MAX_COLS];
    logic [WEIGHT_BITS-1:0] rd_data_reg;
    logic                   mem_re;
    logic [ADDR_W-1:0]      mem_raddr;
    logic                   mem_we;
    logic [ADDR_W-1:0]      mem_waddr;
    logic [WEIGHT_BITS-1:0] mem_wdata;

    logic [CNT_W-1:0]       head_col_wide;
    logic [WIDE_W-1:0]      rd_wide;
    logic [WEIGHT_W-1:0]    rd_sat;
    logic                   out_free;

    assign busy      = (state_reg == ST_INIT);
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Weight as shown on the result, limited to the field's range.
    always_comb
    begin
        head_col_wide = CNT_W'(q_cmd.column);
        rd_wide       = WIDE_W'(rd_data_reg);
        rd_sat        = (rd_wide > WIDE_W'(8'hFF)) ? 8'hFF : rd_wide[WEIGHT_W-1:0];
    end

    // Sequencer for the clearing sweeps and the per-command work.
    always_comb
    begin
        state_next     = state_reg;
        sweep_next     = sweep_reg;
        cur_addr_next  = cur_addr_reg;
        cur_range_next = cur_range_reg;
        cur_add_next   = cur_add_reg;
        nonempty_next  = nonempty_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        q_pop          = 1'b0;
        mem_re         = 1'b0;
        mem_raddr      = head_col_wide[ADDR_W-1:0];
        mem_we         = 1'b0;
        mem_waddr      = sweep_reg[ADDR_W-1:0];
        mem_wdata      = '0;

        unique case (state_reg)
            ST_INIT:
            begin
                // Zero the whole store after reset.
                mem_we     = 1'b1;
                sweep_next = sweep_reg + CNT_W'(1);
                if (sweep_reg == CNT_W'(MAX_COLS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop          = 1'b1;
                    cur_addr_next  = head_col_wide[ADDR_W-1:0];
                    cur_range_next = q_cmd.in_range;
                    unique case (q_cmd.op)
                        OP_CLEAR:
                        begin
                            nonempty_next = '0;
                            total_next    = '0;
                            sweep_next    = '0;
                            if (cols_eff != '0)
                            begin
                                state_next = ST_CLEAR;
                            end
                        end
                        OP_ADD:
                        begin
                            if (q_cmd.in_range)
                            begin
                                mem_re       = 1'b1;
                                cur_add_next = 1'b1;
                                state_next   = ST_ACT;
                            end
                        end
                        OP_READ:
                        begin
                            mem_re       = q_cmd.in_range;
                            cur_add_next = 1'b0;
                            state_next   = ST_ACT;
                        end
                        OP_REPORT:
                        begin
                            cur_range_next = 1'b0;
                            cur_add_next   = 1'b0;
                            state_next     = ST_ACT;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ACT:
            begin
                if (cur_add_reg)
                begin
                    // Saturating increment of the column and the counts.
                    mem_waddr  = cur_addr_reg;
                    mem_wdata  = rd_data_reg + WEIGHT_BITS'(1);
                    mem_we     = (rd_data_reg != W_MAX);
                    if ((rd_data_reg == '0) && (nonempty_reg != {NONEMPTY_W{1'b1}}))
                    begin
                        nonempty_next = nonempty_reg + NONEMPTY_W'(1);
                    end
                    if (total_reg != {TOTAL_W{1'b1}})
                    begin
                        total_next = total_reg + TOTAL_W'(1);
                    end
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    // Load the result register once it is free.
                    out_valid_next                 = 1'b1;
                    out_data_next.weight           = cur_range_reg ? rd_sat : '0;
                    out_data_next.nonempty_columns = nonempty_reg;
                    out_data_next.total_weight     = total_reg;
                    state_next                     = ST_IDLE;
                end
            end
            ST_CLEAR:
            begin
                mem_we     = 1'b1;
                sweep_next = sweep_reg + CNT_W'(1);
                if (sweep_reg == (cols_eff - CNT_W'(1)))
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_INIT;
                sweep_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_INIT;
            sweep_reg     <= '0;
            cur_add_reg   <= 1'b0;
            cur_range_reg <= 1'b0;
            nonempty_reg  <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            cur_add_reg   <= cur_add_next;
            cur_range_reg <= cur_range_next;
            nonempty_reg  <= nonempty_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        cur_addr_reg <= cur_addr_next;
        out_data_reg <= out_data_next;
    end

    // Weight store with registered read data.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

// ===== design/sparse_column_weight_histogram.sv =====
// Results: a read or report result passes from the command queue through the back end's
// act state into the result register once the output is free. Add, read and report pass
// through the idle and act states, a store read and then a write or result load; an add
// outside the columns in effect ends in idle, and a clear zeroes one column per cycle.
// Reset: counts and control clear at once, then a sweep over all MAX_COLS columns zeroes the
// weight store with in_ready held low; configuration writes are taken throughout.
module sparse_column_weight_histogram
    import scwh_pkg::*;
#(
    parameter int MAX_COLS    = MAX_COLS_DEF,
    parameter int WEIGHT_BITS = WEIGHT_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_ready,
    input  in_item_t         in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output out_item_t        out_data
);

    localparam int CNT_W = ($clog2(MAX_COLS + 1) > CFG_W) ? $clog2(MAX_COLS + 1) : CFG_W;

    logic             back_busy;
    logic             q_full;
    logic             q_push;
    cmd_t             q_cmd;
    logic             q_pop;
    logic             q_valid;
    cmd_t             q_head;
    logic [CNT_W-1:0] cols_eff;

    // Accept and classify transactions.
    scwh_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .back_busy (back_busy),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_cmd),
        .cols_eff  (cols_eff)
    );

    // Command queue.
    scwh_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_cmd   (q_head)
    );

    // Carry out commands against the weight store.
    scwh_back #(
        .MAX_COLS    (MAX_COLS),
        .WEIGHT_BITS (WEIGHT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cols_eff  (cols_eff),
        .q_valid   (q_valid),
        .q_cmd     (q_head),
        .q_pop     (q_pop),
        .busy      (back_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
